@@ rtl/core/rcdp_pkg.sv @@
package rcdp_pkg;

  localparam logic [23:0] NOISE_FLOOR  = 24'd42;
  localparam int          CURVE_POINTS = 200;
  localparam int          CURVE_AW     = 8;
  localparam int          WIN_AW       = 6;
  localparam int          SQRT_CYCLES  = 12;  // 24 root bits, two per cycle
  localparam int          DIV_CYCLES   = 20;  // 40 quotient bits, two per cycle
  localparam int          CNT_W        = 5;

  localparam logic [1:0] CMD_PROCESS = 2'd0;
  localparam logic [1:0] CMD_CURVE   = 2'd1;
  localparam logic [1:0] CMD_BYPASS  = 2'd2;

  localparam logic [1:0] MODE_MAX      = 2'd0;
  localparam logic [1:0] MODE_AVG      = 2'd1;
  localparam logic [1:0] MODE_UNLINKED = 2'd2;

  localparam logic [2:0] REG_INPUT_GAIN  = 3'd0;
  localparam logic [2:0] REG_OUTPUT_GAIN = 3'd1;
  localparam logic [2:0] REG_ATTACK      = 3'd2;
  localparam logic [2:0] REG_RELEASE     = 3'd3;
  localparam logic [2:0] REG_STEREO_MODE = 3'd4;
  localparam logic [2:0] REG_DRY_LEVEL   = 3'd5;
  localparam logic [2:0] REG_WET_LEVEL   = 3'd6;

  typedef struct packed {
    logic [15:0] input_gain;
    logic [15:0] output_gain;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
    logic [1:0]  stereo_mode;
    logic [15:0] dry_level;
    logic [15:0] wet_level;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic curve_wr;
    logic bypass;
    logic gain;
    logic square;
    logic sum;
    logic sqrt_step;
    logic fol_mul;
    logic fol_add;
    logic link;
    logic rd0;
    logic rd1;
    logic cap;
    logic imul;
    logic iadd;
    logic gmul;
    logic div_step;
    logic outg;
    logic mix_mul;
    logic mix_add;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
  } dp_sts_t;

endpackage

@@ rtl/core/rcdp_datapath.sv @@
module rcdp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  rcdp_pkg::dp_cmd_t     cmd,
  output rcdp_pkg::dp_sts_t     sts,
  input  rcdp_pkg::cfg_t        cfg,
  input  logic [1:0]            command,
  input  logic signed [15:0]    left_in,
  input  logic signed [15:0]    right_in,
  input  logic [7:0]            curve_index,
  input  logic [15:0]           curve_value,
  input  logic                  end_of_block,
  output logic signed [15:0]    left_out,
  output logic signed [15:0]    right_out,
  output logic                  end_of_block_out
);

  localparam int WIN_AW_C = rcdp_pkg::WIN_AW;

  // latched request
  logic [1:0]         cmd_r;
  logic signed [15:0] x [2];
  logic               eob;
  logic [7:0]         cidx;
  logic [15:0]        cval;

  // detector state
  logic [31:0]        win_l [64];
  logic [31:0]        win_r [64];
  logic [31:0]        win_rd [2];
  logic [WIN_AW_C-1:0] pos;
  logic               wrapped;
  logic [37:0]        sum [2];
  logic [23:0]        lev [2];

  // per-item work registers
  logic signed [15:0] s [2];
  logic [31:0]        sq [2];
  logic [31:0]        old [2];
  logic [47:0]        rad [2];
  logic [25:0]        srem [2];
  logic [23:0]        root [2];
  logic [39:0]        pp [2];
  logic [40:0]        pt [2];
  logic [23:0]        plv [2];
  logic               skip [2];
  logic [31:0]        p200 [2];
  logic [15:0]        c_lo [2];
  logic [15:0]        c_hi [2];
  logic [38:0]        m0 [2];
  logic [37:0]        m1 [2];
  logic [15:0]        g [2];
  logic [39:0]        dvd [2];
  logic [23:0]        drem [2];
  logic               neg [2];
  logic signed [50:0] po [2];
  logic signed [55:0] pw [2];
  logic signed [32:0] pd [2];

  // gain curve
  logic [15:0]        curve_mem [rcdp_pkg::CURVE_POINTS];
  logic [rcdp_pkg::CURVE_POINTS-1:0] curve_vld;
  logic [15:0]        rd_lo, rd_hi;
  logic               rd_lo_v, rd_hi_v;

  // combinational next values
  logic signed [15:0] s_n [2];
  logic [25:0]        srem_n [2];
  logic [23:0]        root_n [2];
  logic [47:0]        rad_n [2];
  logic [23:0]        drem_n [2];
  logic [39:0]        dvd_n [2];
  logic [37:0]        sum_n [2];
  logic [15:0]        a_sel [2];
  logic [23:0]        fol_n [2];
  logic [23:0]        link_n [2];
  logic [7:0]         a_lo [2];
  logic [7:0]         a_hi [2];
  logic               zlo [2];
  logic [21:0]        fr [2];
  logic [31:0]        gmag [2];
  logic signed [32:0] gprod [2];
  logic signed [33:0] q [2];
  logic signed [15:0] mix_n [2];
  logic               sel;

  assign sts.command = cmd_r;
  assign sel = cmd.rd1;

  always_comb begin
    logic signed [32:0] prod;
    logic signed [20:0] sh;
    logic [27:0]        t;
    logic [27:0]        tr;
    logic [24:0]        r;
    logic [41:0]        acc;
    logic [9:0]         idx;
    logic signed [56:0] tot;
    logic signed [41:0] tsh;
    for (int ch = 0; ch < 2; ch++) begin
      // input gain and saturation
      prod = x[ch] * $signed({1'b0, cfg.input_gain});
      sh   = prod[32:12];
      if (sh > 21'sd32767)       s_n[ch] = 16'sh7fff;
      else if (sh < -21'sd32768) s_n[ch] = -16'sh8000;
      else                       s_n[ch] = sh[15:0];

      sum_n[ch] = sum[ch] - 38'(old[ch]) + 38'(sq[ch]);

      // square root, two result bits per cycle
      srem_n[ch] = srem[ch];
      root_n[ch] = root[ch];
      rad_n[ch]  = rad[ch];
      for (int k = 0; k < 2; k++) begin
        t  = {srem_n[ch], rad_n[ch][47:46]};
        tr = {2'b00, root_n[ch], 2'b01};
        if (t >= tr) begin
          srem_n[ch] = 26'(t - tr);
          root_n[ch] = {root_n[ch][22:0], 1'b1};
        end else begin
          srem_n[ch] = t[25:0];
          root_n[ch] = {root_n[ch][22:0], 1'b0};
        end
        rad_n[ch] = {rad_n[ch][45:0], 2'b00};
      end

      // restoring divide, two quotient bits per cycle
      drem_n[ch] = drem[ch];
      dvd_n[ch]  = dvd[ch];
      for (int k = 0; k < 2; k++) begin
        r = {drem_n[ch], dvd_n[ch][39]};
        if (r >= {1'b0, plv[ch]}) begin
          drem_n[ch] = 24'(r - {1'b0, plv[ch]});
          dvd_n[ch]  = {dvd_n[ch][38:0], 1'b1};
        end else begin
          drem_n[ch] = r[23:0];
          dvd_n[ch]  = {dvd_n[ch][38:0], 1'b0};
        end
      end

      // level follower
      a_sel[ch] = (root[ch] > lev[ch]) ? cfg.attack_coeff : cfg.release_coeff;
      acc       = 42'(pp[ch]) + 42'(pt[ch]);
      fol_n[ch] = (acc[41:16] < 26'(rcdp_pkg::NOISE_FLOOR)) ? rcdp_pkg::NOISE_FLOOR
                                                             : acc[39:16];

      // curve addressing
      idx = p200[ch][31:22];
      if (idx == 10'd0) begin
        a_lo[ch] = 8'd0;
        a_hi[ch] = 8'd0;
        zlo[ch]  = 1'b1;
        fr[ch]   = p200[ch][21:0];
      end else if (idx < 10'(rcdp_pkg::CURVE_POINTS)) begin
        a_lo[ch] = 8'(idx - 10'd1);
        a_hi[ch] = idx[7:0];
        zlo[ch]  = 1'b0;
        fr[ch]   = p200[ch][21:0];
      end else begin
        a_lo[ch] = 8'(rcdp_pkg::CURVE_POINTS - 1);
        a_hi[ch] = 8'(rcdp_pkg::CURVE_POINTS - 1);
        zlo[ch]  = 1'b0;
        fr[ch]   = 22'd0;
      end

      gprod[ch] = s[ch] * $signed({1'b0, g[ch]});
      gmag[ch]  = gprod[ch][32] ? 32'(-gprod[ch]) : gprod[ch][31:0];

      if (skip[ch])    q[ch] = 34'(s[ch]);
      else if (neg[ch]) q[ch] = -$signed(dvd[ch][33:0]);
      else             q[ch] = $signed(dvd[ch][33:0]);

      tot = 57'(pw[ch]) + 57'(pd[ch]);
      tsh = tot[56:15];
      if (tsh > 42'sd32767)       mix_n[ch] = 16'sh7fff;
      else if (tsh < -42'sd32768) mix_n[ch] = -16'sh8000;
      else                        mix_n[ch] = tsh[15:0];
    end
  end

  always_comb begin
    logic [24:0] avg;
    avg = 25'(lev[0]) + 25'(lev[1]);
    unique case (cfg.stereo_mode)
      rcdp_pkg::MODE_MAX: begin
        link_n[0] = (lev[0] > lev[1]) ? lev[0] : lev[1];
        link_n[1] = link_n[0];
      end
      rcdp_pkg::MODE_AVG: begin
        link_n[0] = avg[24:1];
        link_n[1] = avg[24:1];
      end
      rcdp_pkg::MODE_UNLINKED: begin
        link_n[0] = lev[0];
        link_n[1] = lev[1];
      end
      default: begin
        link_n[0] = 24'd0;
        link_n[1] = 24'd0;
      end
    endcase
  end

  // control-like state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      wrapped   <= 1'b0;
      sum[0]    <= '0;
      sum[1]    <= '0;
      lev[0]    <= rcdp_pkg::NOISE_FLOOR;
      lev[1]    <= rcdp_pkg::NOISE_FLOOR;
      curve_vld <= '0;
    end else begin
      if (cmd.sum) begin
        sum[0]  <= sum_n[0];
        sum[1]  <= sum_n[1];
        pos     <= pos + 1'b1;
        wrapped <= wrapped | (pos == '1);
      end
      if (cmd.fol_add) begin
        lev[0] <= fol_n[0];
        lev[1] <= fol_n[1];
      end
      if (cmd.bypass) begin
        lev[0] <= rcdp_pkg::NOISE_FLOOR;
        lev[1] <= rcdp_pkg::NOISE_FLOOR;
      end
      if (cmd.curve_wr && cidx < 8'(rcdp_pkg::CURVE_POINTS)) begin
        curve_vld[cidx] <= 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      win_rd[0] <= win_l[pos];
      win_rd[1] <= win_r[pos];
    end
    if (cmd.sum) begin
      win_l[pos] <= sq[0];
      win_r[pos] <= sq[1];
    end
    if (cmd.curve_wr && cidx < 8'(rcdp_pkg::CURVE_POINTS)) begin
      curve_mem[cidx] <= cval;
    end
    if (cmd.rd0 || cmd.rd1) begin
      rd_lo   <= curve_mem[a_lo[sel]];
      rd_hi   <= curve_mem[a_hi[sel]];
      rd_lo_v <= curve_vld[a_lo[sel]];
      rd_hi_v <= curve_vld[a_hi[sel]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= command;
      x[0]  <= left_in;
      x[1]  <= right_in;
      eob   <= end_of_block;
      cidx  <= curve_index;
      cval  <= curve_value;
    end
    if (cmd.rd1) begin
      c_lo[0] <= (zlo[0] || !rd_lo_v) ? 16'd0 : rd_lo;
      c_hi[0] <= rd_hi_v ? rd_hi : 16'd0;
    end
    if (cmd.cap) begin
      c_lo[1] <= (zlo[1] || !rd_lo_v) ? 16'd0 : rd_lo;
      c_hi[1] <= rd_hi_v ? rd_hi : 16'd0;
    end
    for (int ch = 0; ch < 2; ch++) begin
      if (cmd.gain) s[ch] <= s_n[ch];
      if (cmd.square) begin
        sq[ch]  <= 32'(s[ch] * s[ch]);
        old[ch] <= wrapped ? win_rd[ch] : 32'd0;
      end
      if (cmd.sum) begin
        rad[ch]  <= {2'b00, sum_n[ch][37:6], 14'd0};
        srem[ch] <= '0;
        root[ch] <= '0;
      end
      if (cmd.sqrt_step) begin
        rad[ch]  <= rad_n[ch];
        srem[ch] <= srem_n[ch];
        root[ch] <= root_n[ch];
      end
      if (cmd.fol_mul) begin
        pp[ch] <= lev[ch] * a_sel[ch];
        pt[ch] <= (17'h10000 - 17'(a_sel[ch])) * root[ch];
      end
      if (cmd.link) begin
        plv[ch]  <= link_n[ch];
        skip[ch] <= link_n[ch] <= rcdp_pkg::NOISE_FLOOR;
        p200[ch] <= link_n[ch] * 8'(rcdp_pkg::CURVE_POINTS);
      end
      if (cmd.imul) begin
        m0[ch] <= c_lo[ch] * (23'h400000 - 23'(fr[ch]));
        m1[ch] <= c_hi[ch] * fr[ch];
      end
      if (cmd.iadd) g[ch] <= 16'((40'(m0[ch]) + 40'(m1[ch])) >> 22);
      if (cmd.gmul) begin
        dvd[ch]  <= {1'b0, gmag[ch], 7'd0};
        neg[ch]  <= gprod[ch][32];
        drem[ch] <= '0;
      end
      if (cmd.div_step) begin
        dvd[ch]  <= dvd_n[ch];
        drem[ch] <= drem_n[ch];
      end
      if (cmd.outg) po[ch] <= q[ch] * $signed({1'b0, cfg.output_gain});
      if (cmd.mix_mul) begin
        pw[ch] <= $signed({1'b0, cfg.wet_level}) * $signed(po[ch][50:12]);
        pd[ch] <= $signed({1'b0, cfg.dry_level}) * x[ch];
      end
    end
    if (cmd.mix_add) begin
      left_out         <= mix_n[0];
      right_out        <= mix_n[1];
      end_of_block_out <= eob;
    end
    if (cmd.bypass) begin
      left_out         <= x[0];
      right_out        <= x[1];
      end_of_block_out <= eob;
    end
  end

endmodule

@@ rtl/core/rcdp_ctrl.sv @@
module rcdp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rcdp_pkg::dp_sts_t sts,
  output rcdp_pkg::dp_cmd_t cmd
);

  typedef enum logic [20:0] {
    ST_IDLE   = 21'h000001,
    ST_DECODE = 21'h000002,
    ST_CWR    = 21'h000004,
    ST_BYP    = 21'h000008,
    ST_GAIN   = 21'h000010,
    ST_SQ     = 21'h000020,
    ST_SUM    = 21'h000040,
    ST_SQRT   = 21'h000080,
    ST_FMUL   = 21'h000100,
    ST_FADD   = 21'h000200,
    ST_LINK   = 21'h000400,
    ST_RD0    = 21'h000800,
    ST_RD1    = 21'h001000,
    ST_CAP    = 21'h002000,
    ST_IMUL   = 21'h004000,
    ST_IADD   = 21'h008000,
    ST_GMUL   = 21'h010000,
    ST_DIV    = 21'h020000,
    ST_OUTG   = 21'h040000,
    ST_MMUL   = 21'h080000,
    ST_MADD   = 21'h100000
  } state_t;

  state_t                       state, state_next;
  logic [rcdp_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                         out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority case (sts.command)
          rcdp_pkg::CMD_PROCESS: state_next = ST_GAIN;
          rcdp_pkg::CMD_CURVE:   state_next = ST_CWR;
          rcdp_pkg::CMD_BYPASS:  state_next = ST_BYP;
          default:               state_next = ST_IDLE;
        endcase
      end
      ST_CWR: begin
        cmd.curve_wr = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_BYP: begin
        if (out_free) begin
          cmd.bypass = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_GAIN: begin cmd.gain = 1'b1;    state_next = ST_SQ;   end
      ST_SQ:   begin cmd.square = 1'b1;  state_next = ST_SUM;  end
      ST_SUM:  begin cmd.sum = 1'b1;     state_next = ST_SQRT; end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == rcdp_pkg::CNT_W'(rcdp_pkg::SQRT_CYCLES - 1)) state_next = ST_FMUL;
        else cnt_next = cnt + 1'b1;
      end
      ST_FMUL: begin cmd.fol_mul = 1'b1; state_next = ST_FADD; end
      ST_FADD: begin cmd.fol_add = 1'b1; state_next = ST_LINK; end
      ST_LINK: begin cmd.link = 1'b1;    state_next = ST_RD0;  end
      ST_RD0:  begin cmd.rd0 = 1'b1;     state_next = ST_RD1;  end
      ST_RD1:  begin cmd.rd1 = 1'b1;     state_next = ST_CAP;  end
      ST_CAP:  begin cmd.cap = 1'b1;     state_next = ST_IMUL; end
      ST_IMUL: begin cmd.imul = 1'b1;    state_next = ST_IADD; end
      ST_IADD: begin cmd.iadd = 1'b1;    state_next = ST_GMUL; end
      ST_GMUL: begin cmd.gmul = 1'b1;    state_next = ST_DIV;  end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == rcdp_pkg::CNT_W'(rcdp_pkg::DIV_CYCLES - 1)) state_next = ST_OUTG;
        else cnt_next = cnt + 1'b1;
      end
      ST_OUTG: begin cmd.outg = 1'b1;    state_next = ST_MMUL; end
      ST_MMUL: begin cmd.mix_mul = 1'b1; state_next = ST_MADD; end
      ST_MADD: begin
        if (out_free) begin
          cmd.mix_add = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.mix_add || cmd.bypass) out_valid <= 1'b1;
      else if (out_ready)            out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/rms_curve_dynamics_processor.sv @@
// Stereo RMS compressor with a stored 200-point gain curve. One request at a
// time: command 0 processes a frame and raises its result once the square
// root and the divide are through, both radix-4 and shared by neither
// channel (each channel has its own). Command 1 writes a curve point with no
// result; command 2 resets both levels and raises the input unchanged as its
// result; command 3 is dropped. A finished result sits in an output register,
// so the next request is taken while it waits; only the final write of the
// next result stalls on it. Curve points never written read as zero; no
// clearing pass is needed after reset. Configuration is always ready and
// should be written only while the block is idle.
module rms_curve_dynamics_processor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  input  logic [7:0]         curve_index,
  input  logic [15:0]        curve_value,
  input  logic               end_of_block,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic               end_of_block_out
);

  rcdp_pkg::cfg_t    cfg;
  rcdp_pkg::dp_cmd_t cmd;
  rcdp_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_gain    <= 16'd4096;
      cfg.output_gain   <= 16'd4096;
      cfg.attack_coeff  <= 16'd65000;
      cfg.release_coeff <= 16'd65500;
      cfg.stereo_mode   <= rcdp_pkg::MODE_MAX;
      cfg.dry_level     <= 16'd0;
      cfg.wet_level     <= 16'd32768;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcdp_pkg::REG_INPUT_GAIN:  cfg.input_gain    <= cfg_data;
        rcdp_pkg::REG_OUTPUT_GAIN: cfg.output_gain   <= cfg_data;
        rcdp_pkg::REG_ATTACK:      cfg.attack_coeff  <= cfg_data;
        rcdp_pkg::REG_RELEASE:     cfg.release_coeff <= cfg_data;
        rcdp_pkg::REG_STEREO_MODE: cfg.stereo_mode   <= cfg_data[1:0];
        rcdp_pkg::REG_DRY_LEVEL:   cfg.dry_level     <= cfg_data;
        rcdp_pkg::REG_WET_LEVEL:   cfg.wet_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: at most one command per cycle into the datapath
  rcdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // detector, follower, curve lookup, divide and mix
  rcdp_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg              (cfg),
    .command          (command),
    .left_in          (left_in),
    .right_in         (right_in),
    .curve_index      (curve_index),
    .curve_value      (curve_value),
    .end_of_block     (end_of_block),
    .left_out         (left_out),
    .right_out        (right_out),
    .end_of_block_out (end_of_block_out)
  );

  // at most one datapath command per cycle
  assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");

  // a request is taken only once; decode follows
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted back to back");

  // a result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
      (cmd.mix_add || cmd.bypass) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // a taken result with nothing new behind it clears valid
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_ready && !cmd.mix_add && !cmd.bypass) |=> !out_valid)
    else $error("result repeated");

endmodule
